// ----- rtl/core/multi_pattern_suffix_matcher_assert.svh -----
// Assertion macros for the multi-pattern suffix matcher.
`ifndef MULTI_PATTERN_SUFFIX_MATCHER_ASSERT_SVH
`define MULTI_PATTERN_SUFFIX_MATCHER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define MPSM_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mpsm assertion failed");

// Next-cycle implication, disabled during reset.
`define MPSM_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mpsm assertion failed");

`endif

// ----- rtl/core/mpsm_pkg.sv -----
// Package: constants, codes and types of the multi-pattern suffix matcher.
package mpsm_pkg;

  localparam int MAX_BUFFER    = 64;
  localparam int NUM_PATTERNS  = 4;
  localparam int PATTERN_BYTES = 8;

  localparam int SLOT_COUNT = 4;
  localparam int PAT_W      = 64;
  localparam int LEN_W      = 4;
  localparam int BYTE_W     = 8;
  localparam int HIST_W     = PATTERN_BYTES * BYTE_W;
  localparam int CNT_W      = $clog2(MAX_BUFFER + 1);
  localparam int CMP_W      = (CNT_W > LEN_W) ? CNT_W : LEN_W;
  localparam int IDX_W      = 2;
  localparam int USED_W     = 7;
  localparam int REG_IDX_W  = 3;

  localparam logic OUTCOME_MATCH   = 1'b0;
  localparam logic OUTCOME_TIMEOUT = 1'b1;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_PATTERN_A = 3'd0,
    REG_PATTERN_B = 3'd1,
    REG_PATTERN_C = 3'd2,
    REG_PATTERN_D = 3'd3,
    REG_LENGTH_A  = 3'd4,
    REG_LENGTH_B  = 3'd5,
    REG_LENGTH_C  = 3'd6,
    REG_LENGTH_D  = 3'd7
  } reg_index_t;

  typedef struct packed {
    logic [SLOT_COUNT-1:0][PAT_W-1:0] pattern;
    logic [SLOT_COUNT-1:0][LEN_W-1:0] length;
  } cfg_t;

endpackage

// ----- rtl/core/mpsm_if.sv -----
// Interfaces: byte input channel and result channel.
interface mpsm_byte_if;
  logic                             valid;
  logic                             ready;
  logic [mpsm_pkg::BYTE_W-1:0]      byte_in;

  modport source (output valid, output byte_in, input ready);
  modport sink   (input valid, input byte_in, output ready);
endinterface

interface mpsm_result_if;
  logic                             valid;
  logic                             ready;
  logic                             outcome;
  logic [mpsm_pkg::IDX_W-1:0]       pattern_index;
  logic [mpsm_pkg::USED_W-1:0]      bytes_used;

  modport source (output valid, output outcome, output pattern_index, output bytes_used,
                  input ready);
  modport sink   (input valid, input outcome, input pattern_index, input bytes_used,
                  output ready);
endinterface

// ----- rtl/core/mpsm_cfg_regs.sv -----
// Configuration register file: four patterns and four lengths.
module mpsm_cfg_regs (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wr_en,
  input  logic [mpsm_pkg::REG_IDX_W-1:0]    cfg_index,
  input  logic [mpsm_pkg::PAT_W-1:0]        cfg_data,
  output mpsm_pkg::cfg_t                    cfg
);

  mpsm_pkg::reg_index_t idx;
  assign idx = mpsm_pkg::reg_index_t'(cfg_index);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_wr_en) begin
      case (idx)
        mpsm_pkg::REG_PATTERN_A: cfg.pattern[0] <= cfg_data;
        mpsm_pkg::REG_PATTERN_B: cfg.pattern[1] <= cfg_data;
        mpsm_pkg::REG_PATTERN_C: cfg.pattern[2] <= cfg_data;
        mpsm_pkg::REG_PATTERN_D: cfg.pattern[3] <= cfg_data;
        mpsm_pkg::REG_LENGTH_A:  cfg.length[0]  <= cfg_data[mpsm_pkg::LEN_W-1:0];
        mpsm_pkg::REG_LENGTH_B:  cfg.length[1]  <= cfg_data[mpsm_pkg::LEN_W-1:0];
        mpsm_pkg::REG_LENGTH_C:  cfg.length[2]  <= cfg_data[mpsm_pkg::LEN_W-1:0];
        mpsm_pkg::REG_LENGTH_D:  cfg.length[3]  <= cfg_data[mpsm_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/core/mpsm_slot_compare.sv -----
// One pattern slot: suffix compare of the history against the pattern.
module mpsm_slot_compare (
  input  logic [mpsm_pkg::HIST_W-1:0]  history,
  input  logic [mpsm_pkg::PAT_W-1:0]   pattern,
  input  logic [mpsm_pkg::LEN_W-1:0]   length,
  input  logic [mpsm_pkg::CNT_W-1:0]   count,
  output logic                         hit
);

  localparam logic [mpsm_pkg::LEN_W-1:0] LenCap = mpsm_pkg::LEN_W'(mpsm_pkg::PATTERN_BYTES);

  logic [mpsm_pkg::LEN_W-1:0]         len_eff;
  logic [mpsm_pkg::PATTERN_BYTES-1:0] byte_ok;
  logic                               enough;

  assign len_eff = (length > LenCap) ? LenCap : length;
  assign enough  = mpsm_pkg::CMP_W'(count) >= mpsm_pkg::CMP_W'(len_eff);

  always_comb begin
    for (int k = 0; k < mpsm_pkg::PATTERN_BYTES; k++) begin
      byte_ok[k] = (mpsm_pkg::LEN_W'(k) >= len_eff) ||
                   (history[k*mpsm_pkg::BYTE_W +: mpsm_pkg::BYTE_W] ==
                    pattern[k*mpsm_pkg::BYTE_W +: mpsm_pkg::BYTE_W]);
    end
  end

  assign hit = (len_eff != '0) && enough && (&byte_ok);

endmodule

// ----- rtl/core/multi_pattern_suffix_matcher.sv -----
// Top level: multi-pattern suffix matcher over a received byte stream.
//
// Bytes arrive one word per handshake on byte_chan (valid/ready). Each
// byte lands in an input register; from there it is shifted into
// the eight-byte history and tested against up to four configured
// patterns in slot order. A match, or MAX_BUFFER bytes without one,
// loads a result word into the output register on result_chan; bytes
// that decide nothing give no word. Throughput is one byte per cycle
// unless the receiver stalls, set by the single history/compare stage
// between the input and output registers. Once a result is given the
// history and byte count are cleared. Configuration is written through
// cfg_wr_en/cfg_index/cfg_data; the user must do so only while the block
// is idle, which the block does not enforce. Synchronous reset clears
// patterns, lengths, history, count and both register stages. When the
// receiver stalls, one pending result is held and one further byte is
// buffered, then ready drops.
`include "multi_pattern_suffix_matcher_assert.svh"

module multi_pattern_suffix_matcher (
  input  logic                              clk,
  input  logic                              rst,
  mpsm_byte_if.sink                         byte_chan,
  mpsm_result_if.source                     result_chan,
  input  logic                              cfg_wr_en,
  input  logic [mpsm_pkg::REG_IDX_W-1:0]    cfg_index,
  input  logic [mpsm_pkg::PAT_W-1:0]        cfg_data
);

  localparam logic [mpsm_pkg::CNT_W-1:0] MaxCount = mpsm_pkg::CNT_W'(mpsm_pkg::MAX_BUFFER);

  mpsm_pkg::cfg_t cfg;

  logic                              in_valid;
  logic [mpsm_pkg::BYTE_W-1:0]       in_byte;
  logic [mpsm_pkg::HIST_W-1:0]       history;
  logic [mpsm_pkg::CNT_W-1:0]        count;

  logic [mpsm_pkg::HIST_W-1:0]       history_next;
  logic [mpsm_pkg::CNT_W-1:0]        count_next;
  logic [mpsm_pkg::NUM_PATTERNS-1:0] slot_hit;
  logic                              any_match;
  logic [mpsm_pkg::IDX_W-1:0]        win_index;
  logic                              timeout;
  logic                              decide;
  logic                              proc;

  logic                              out_valid;
  logic                              out_outcome;
  logic [mpsm_pkg::IDX_W-1:0]        out_index;
  logic [mpsm_pkg::USED_W-1:0]       out_used;

  mpsm_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  assign history_next = {history[mpsm_pkg::HIST_W-mpsm_pkg::BYTE_W-1:0], in_byte};
  assign count_next   = (count < MaxCount) ? count + mpsm_pkg::CNT_W'(1) : count;

  for (genvar s = 0; s < mpsm_pkg::NUM_PATTERNS; s++) begin : g_slot
    mpsm_slot_compare u_cmp (
      .history (history_next),
      .pattern (cfg.pattern[s]),
      .length  (cfg.length[s]),
      .count   (count_next),
      .hit     (slot_hit[s])
    );
  end

  // first slot in list order wins
  always_comb begin
    win_index = '0;
    for (int s = mpsm_pkg::NUM_PATTERNS - 1; s >= 0; s--) begin
      if (slot_hit[s]) begin
        win_index = mpsm_pkg::IDX_W'(s);
      end
    end
  end

  assign any_match = |slot_hit;
  assign timeout   = count_next >= MaxCount;
  assign decide    = any_match || timeout;
  assign proc      = in_valid && (!out_valid || result_chan.ready);

  assign byte_chan.ready = !in_valid || proc;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (byte_chan.valid && byte_chan.ready) begin
      in_valid <= 1'b1;
    end else if (proc) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_chan.valid && byte_chan.ready) begin
      in_byte <= byte_chan.byte_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      history <= '0;
      count   <= '0;
    end else if (proc) begin
      history <= decide ? '0 : history_next;
      count   <= decide ? '0 : count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (proc && decide) begin
      out_valid <= 1'b1;
    end else if (result_chan.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc && decide) begin
      out_outcome <= any_match ? mpsm_pkg::OUTCOME_MATCH : mpsm_pkg::OUTCOME_TIMEOUT;
      out_index   <= any_match ? win_index : '0;
      out_used    <= mpsm_pkg::USED_W'(count_next);
    end
  end

  assign result_chan.valid         = out_valid;
  assign result_chan.outcome       = out_outcome;
  assign result_chan.pattern_index = out_index;
  assign result_chan.bytes_used    = out_used;

  `MPSM_ASSERT_IMPL(a_count_bound, clk, rst, 1'b1, count <= MaxCount)
  `MPSM_ASSERT_NEXT(a_rearm, clk, rst, proc && decide, count == '0 && history == '0)
  `MPSM_ASSERT_IMPL(a_timeout_index, clk, rst,
    out_valid && out_outcome == mpsm_pkg::OUTCOME_TIMEOUT, out_index == '0)

endmodule

// ----- tb/multi_pattern_suffix_matcher_tb.sv -----
// Self-checking testbench of the multi-pattern suffix matcher: table of probes, then random streams.
module multi_pattern_suffix_matcher_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 300;
  localparam int NUM_PHASES    = 12;
  localparam int PHASE_WORDS   = 140;
  localparam int PROBE_COUNT   = 22;

  typedef enum logic [1:0] {
    CHK_MODEL,
    CHK_NONE,
    CHK_HIT
  } check_t;

  typedef struct packed {
    logic                        outcome;
    logic [mpsm_pkg::IDX_W-1:0]  pattern_index;
    logic [mpsm_pkg::USED_W-1:0] bytes_used;
  } match_word_t;

  typedef struct packed {
    logic [mpsm_pkg::BYTE_W-1:0] b;
    check_t                      chk;
    match_word_t                 hit;
  } probe_row_t;

  // slot a: 01 02 with junk above, b: 02, c: eight FF (length 15), d: eight zero bytes
  localparam mpsm_pkg::cfg_t PROBE_CFG = '{
    pattern: '{64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FF02, 64'hDEAD_BEEF_CAFE_0102},
    length:  '{4'd8, 4'd15, 4'd1, 4'd2}
  };

  localparam probe_row_t PROBE_ROWS [PROBE_COUNT] = '{
    '{8'h00, CHK_NONE,  '0},
    '{8'h00, CHK_MODEL, '0},
    '{8'h00, CHK_MODEL, '0},
    '{8'h00, CHK_MODEL, '0},
    '{8'h00, CHK_MODEL, '0},
    '{8'h00, CHK_MODEL, '0},
    '{8'h00, CHK_MODEL, '0},
    '{8'h00, CHK_HIT,   '{mpsm_pkg::OUTCOME_MATCH, 2'd3, 7'd8}},
    '{8'h01, CHK_MODEL, '0},
    '{8'h02, CHK_HIT,   '{mpsm_pkg::OUTCOME_MATCH, 2'd0, 7'd2}},
    '{8'h05, CHK_MODEL, '0},
    '{8'h02, CHK_HIT,   '{mpsm_pkg::OUTCOME_MATCH, 2'd1, 7'd2}},
    '{8'h7F, CHK_MODEL, '0},
    '{8'h80, CHK_MODEL, '0},
    '{8'hFF, CHK_MODEL, '0},
    '{8'hFF, CHK_MODEL, '0},
    '{8'hFF, CHK_MODEL, '0},
    '{8'hFF, CHK_MODEL, '0},
    '{8'hFF, CHK_MODEL, '0},
    '{8'hFF, CHK_MODEL, '0},
    '{8'hFF, CHK_MODEL, '0},
    '{8'hFF, CHK_HIT,   '{mpsm_pkg::OUTCOME_MATCH, 2'd2, 7'd10}}
  };

  logic clk;
  logic rst;
  logic cfg_wr_en;
  logic [mpsm_pkg::REG_IDX_W-1:0] cfg_index;
  logic [mpsm_pkg::PAT_W-1:0] cfg_data;

  mpsm_byte_if   byte_ch ();
  mpsm_result_if res_ch ();

  multi_pattern_suffix_matcher DUT (
    .clk         (clk),
    .rst         (rst),
    .byte_chan   (byte_ch),
    .result_chan (res_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  // search state and slot registers as the block should hold them
  logic [mpsm_pkg::PAT_W-1:0]  slot_pat [mpsm_pkg::SLOT_COUNT] = '{default: '0};
  logic [mpsm_pkg::LEN_W-1:0]  slot_len [mpsm_pkg::SLOT_COUNT] = '{default: '0};
  logic [mpsm_pkg::HIST_W-1:0] srch_hist = '0;
  int unsigned                 srch_cnt = 0;

  match_word_t pending_matches [$];
  int errors = 0;
  int words_sent = 0;
  int cycles = 0;
  int src_idle_pct = 37;
  int sink_idle_pct = 72;
  bit hold_req = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int eff_len(input int s);
    eff_len = (slot_len[s] > mpsm_pkg::PATTERN_BYTES) ? mpsm_pkg::PATTERN_BYTES
                                                      : int'(slot_len[s]);
  endfunction

  function automatic bit scan_byte(input logic [mpsm_pkg::BYTE_W-1:0] b,
                                   output match_word_t r);
    int s;
    int n;
    logic [mpsm_pkg::HIST_W-1:0] m;
    scan_byte = 1'b0;
    r = '0;
    srch_hist = {srch_hist[mpsm_pkg::HIST_W-mpsm_pkg::BYTE_W-1:0], b};
    if (srch_cnt < mpsm_pkg::MAX_BUFFER) srch_cnt++;
    for (s = 0; s < mpsm_pkg::NUM_PATTERNS; s++) begin
      n = eff_len(s);
      if (!scan_byte && n != 0 && srch_cnt >= n) begin
        m = (n >= 8) ? '1 : ((64'd1 << (8 * n)) - 64'd1);
        if ((srch_hist & m) == (slot_pat[s] & m)) begin
          scan_byte = 1'b1;
          r = '{mpsm_pkg::OUTCOME_MATCH, 2'(s), 7'(srch_cnt)};
        end
      end
    end
    if (!scan_byte && srch_cnt >= mpsm_pkg::MAX_BUFFER) begin
      scan_byte = 1'b1;
      r = '{mpsm_pkg::OUTCOME_TIMEOUT, 2'd0, 7'(srch_cnt)};
    end
    if (scan_byte) begin
      srch_hist = '0;
      srch_cnt = 0;
    end
  endfunction

  // entered and left just after a falling edge
  task automatic push_byte(input logic [mpsm_pkg::BYTE_W-1:0] b, input check_t chk = CHK_MODEL,
                           input match_word_t hit = '0);
    match_word_t r;
    bit got;
    while ($urandom_range(99) < src_idle_pct) begin
      byte_ch.valid = 1'b0;
      @(negedge clk);
    end
    byte_ch.valid = 1'b1;
    byte_ch.byte_in = b;
    do @(posedge clk); while (!byte_ch.ready);
    got = scan_byte(b, r);
    if (chk == CHK_HIT) pending_matches.push_back(hit);
    else if (chk == CHK_MODEL && got) pending_matches.push_back(r);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    byte_ch.valid = 1'b0;
    while (pending_matches.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic load_config(input mpsm_pkg::cfg_t c);
    int i;
    mpsm_pkg::reg_index_t idx;
    for (i = 0; i < 2 * mpsm_pkg::SLOT_COUNT; i++) begin
      idx = mpsm_pkg::reg_index_t'(i);
      cfg_wr_en = 1'b1;
      cfg_index = idx;
      if (idx < mpsm_pkg::REG_LENGTH_A) begin
        cfg_data = c.pattern[i];
        slot_pat[i] = c.pattern[i];
      end else begin
        cfg_data = mpsm_pkg::PAT_W'(c.length[i - mpsm_pkg::REG_LENGTH_A]);
        slot_len[i - mpsm_pkg::REG_LENGTH_A] = c.length[i - mpsm_pkg::REG_LENGTH_A];
      end
      @(negedge clk);
    end
    cfg_wr_en = 1'b0;
  endtask

  // mostly well-formed pattern runs with noise, spoilt runs and searches that hit the limit
  task automatic stream_phase(input int n_words);
    int start, s, n, i, pick, spoil_at;
    logic [mpsm_pkg::BYTE_W-1:0] b;
    start = words_sent;
    while (words_sent - start < n_words) begin
      s = $urandom_range(0, mpsm_pkg::SLOT_COUNT - 1);
      n = eff_len(s);
      pick = $urandom_range(99);
      if (pick < 10 || n == 0) begin
        push_byte(8'($urandom_range(0, 255)));
      end else if (pick < 13) begin
        // filler keeps bit 7 low so the pattern's last byte lands on the limit
        while (srch_cnt != mpsm_pkg::MAX_BUFFER - n) push_byte(8'($urandom_range(0, 127)));
        for (i = n - 1; i >= 0; i--) push_byte(slot_pat[s][8 * i +: 8]);
      end else begin
        repeat ($urandom_range(0, 3)) push_byte(8'($urandom_range(0, 255)));
        spoil_at = ($urandom_range(9) == 0) ? $urandom_range(0, n - 1) : -1;
        for (i = n - 1; i >= 0; i--) begin
          b = slot_pat[s][8 * i +: 8];
          if (i == spoil_at) b ^= 8'($urandom_range(1, 255));
          push_byte(b);
        end
      end
    end
  endtask

  initial begin
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        res_ch.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      res_ch.ready = ($urandom_range(99) >= sink_idle_pct);
    end
  end

  always @(posedge clk) begin
    match_word_t got, want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      got = '{res_ch.outcome, res_ch.pattern_index, res_ch.bytes_used};
      if (pending_matches.size() == 0) begin
        errors++;
        $display("%0t: unexpected word: outcome %0d index %0d used %0d",
                 $time, got.outcome, got.pattern_index, got.bytes_used);
      end else begin
        want = pending_matches.pop_front();
        if (got.outcome !== want.outcome) begin
          errors++;
          $display("%0t: outcome expected %0d actual %0d", $time, want.outcome, got.outcome);
        end
        if (got.pattern_index !== want.pattern_index) begin
          errors++;
          $display("%0t: pattern_index expected %0d actual %0d",
                   $time, want.pattern_index, got.pattern_index);
        end
        if (got.bytes_used !== want.bytes_used) begin
          errors++;
          $display("%0t: bytes_used expected %0d actual %0d",
                   $time, want.bytes_used, got.bytes_used);
        end
      end
    end
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    mpsm_pkg::cfg_t c;
    int p, i, s;
    rst = 1'b1;
    byte_ch.valid = 1'b0;
    byte_ch.byte_in = '0;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    load_config(PROBE_CFG);
    for (i = 0; i < PROBE_COUNT; i++) begin
      push_byte(PROBE_ROWS[i].b, PROBE_ROWS[i].chk, PROBE_ROWS[i].hit);
    end

    for (p = 0; p < NUM_PHASES; p++) begin
      wait_idle();
      for (s = 0; s < mpsm_pkg::SLOT_COUNT; s++) begin
        c.pattern[s] = {$urandom, $urandom};
        if (p % 2 == 1) c.pattern[s] |= 64'h8080_8080_8080_8080;
        case ($urandom_range(0, 9))
          0: begin
            c.length[s] = '0;
          end
          9: begin
            c.length[s] = 4'($urandom_range(9, 15));
          end
          default: begin
            c.length[s] = 4'($urandom_range(1, mpsm_pkg::PATTERN_BYTES));
          end
        endcase
      end
      if (p == 0) begin
        c.length = '0;
        c.pattern = '1;
      end
      if (p == 5) begin
        c.length = {mpsm_pkg::SLOT_COUNT{4'd8}};
        c.pattern[0] = '0;
        c.pattern[1] = '1;
      end
      if (p == 10) c.length = {mpsm_pkg::SLOT_COUNT{4'd15}};
      load_config(c);
      case (p / 4)
        0: begin
          src_idle_pct = 37;
          sink_idle_pct = 72;
        end
        1: begin
          src_idle_pct = 72;
          sink_idle_pct = 37;
        end
        default: begin
          src_idle_pct = 0;
          sink_idle_pct = 0;
        end
      endcase
      // long receiver stall so the block backs up onto its input
      if (p == 9) hold_req = 1'b1;
      stream_phase(PHASE_WORDS);
    end

    wait_idle();
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/mpsm_pkg.sv
rtl/core/mpsm_if.sv
rtl/core/mpsm_cfg_regs.sv
rtl/core/mpsm_slot_compare.sv
rtl/core/multi_pattern_suffix_matcher.sv
tb/multi_pattern_suffix_matcher_tb.sv
